@@ hdl/nonlinear_sqrt_pd_controller_defines.svh @@
// Assertion helpers included by the controller.
`ifndef NONLINEAR_SQRT_PD_CONTROLLER_DEFINES_SVH
`define NONLINEAR_SQRT_PD_CONTROLLER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define NSPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nspd check failed");

// Implication with the consequent checked in the next cycle.
`define NSPD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nspd check failed");

`endif

@@ hdl/nspd_pkg.sv @@
package nspd_pkg;

	// signed range of every value and saturating sum or product
	localparam int unsigned DATA_WIDTH = 32;

	typedef struct packed {
		logic signed [31:0] setpoint;
		logic signed [31:0] measured;
		logic               wrap_enable;
		logic signed [31:0] half_period;
		logic        [23:0] elapsed_us;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic               in_dead_band;
	} out_item_t;

	localparam logic [2:0] REG_GAIN_P  = 3'd0;
	localparam logic [2:0] REG_GAIN_D  = 3'd1;
	localparam logic [2:0] REG_ACCEL   = 3'd2;
	localparam logic [2:0] REG_LINEAR  = 3'd3;
	localparam logic [2:0] REG_LIMIT   = 3'd4;
	localparam logic [2:0] REG_DEAD    = 3'd5;
	localparam logic [2:0] REG_KNEE_X  = 3'd6;
	localparam logic [2:0] REG_KNEE_Y  = 3'd7;

	localparam int unsigned DT_FLOOR_US = 100;
	localparam int unsigned US_PER_S    = 1000000;

	// Shared unit request/status bundle.
	typedef enum logic [1:0] {
		OP_SQRT = 2'd0,
		OP_DIV  = 2'd1
	} iter_op_t;

	typedef struct packed {
		logic     start;
		iter_op_t op;
	} iter_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iter_sts_t;

endpackage

@@ hdl/nonlinear_sqrt_pd_controller.sv @@
// Nonlinear PD controller with square-root profile, fixed point with
// FRAC_BITS fraction bits. One item at a time: in_ready drops when a beat is
// taken and rises again once the result beat leaves the output register.
// The error is formed and wrapped, then tested against the dead band. A
// dead-band hit has its result beat set valid straight from the error state. A
// linear-band item takes 5 partial-product steps on the shared 32x32
// multiplier; the square-root branch takes 5 multiplier steps, then 64 root
// steps on the shared shift-subtract unit plus hand-off. A nonzero gain_d
// adds 10 multiplier steps for the product and the 1e6 scale, then a 128-step
// division. Config writes go straight to registers and must only happen while
// the block is idle.
`include "nonlinear_sqrt_pd_controller_defines.svh"
module nonlinear_sqrt_pd_controller import nspd_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int unsigned W = 66;  // working width for signed values
	localparam logic signed [W-1:0] VMAX = W'((65'sd1 <<< (DATA_WIDTH - 1)) - 1);
	localparam logic signed [W-1:0] VMIN = -VMAX - 1;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_ERR   = 9'b000000010,
		ST_PMUL  = 9'b000000100,
		ST_SQRT  = 9'b000001000,
		ST_DMUL  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_SUM   = 9'b001000000,
		ST_OUT   = 9'b010000000,
		ST_WAIT  = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] gain_p_q, gain_d_q, knee_x_q, knee_y_q;
	logic        [30:0] accel_q, linear_q, limit_q, dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0; gain_d_q <= '0; knee_x_q <= '0; knee_y_q <= '0;
			accel_q  <= '0; linear_q <= '0; limit_q  <= '0; dead_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_D: gain_d_q <= cfg_data;
				REG_ACCEL:  accel_q  <= cfg_data[30:0];
				REG_LINEAR: linear_q <= cfg_data[30:0];
				REG_LIMIT:  limit_q  <= cfg_data[30:0];
				REG_DEAD:   dead_q   <= cfg_data[30:0];
				REG_KNEE_X: knee_x_q <= cfg_data;
				REG_KNEE_Y: knee_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic signed [W-1:0] sat_f(input logic signed [W-1:0] v);
		if (v > VMAX) return VMAX;
		if (v < VMIN) return VMIN;
		return v;
	endfunction

	// item registers
	in_item_t           item_q;
	logic signed [W-1:0] err_q, prev_q, drive_q, dterm_q;
	logic        [63:0] ma_q, mb_q;      // magnitudes fed to the multiplier
	logic               neg_q;
	logic       [127:0] acc_q;           // partial-product accumulator
	logic         [3:0] step_q;          // partial-product step
	logic        [23:0] dt_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	nspd_mul_unit #(.W(32)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	// shared iterative unit
	iter_ctl_t   it_ctl;
	iter_sts_t   it_sts;
	logic [127:0] it_num;
	logic  [63:0] it_den;
	logic [127:0] it_res;
	nspd_iter_unit #(.NUM_WIDTH(128), .DEN_WIDTH(64)) u_iter (
		.clk(clk), .arst_n(arst_n), .ctl(it_ctl), .num(it_num), .den(it_den),
		.sts(it_sts), .result(it_res)
	);

	// Partial-product sequence: steps 0..3 issue al*bl, al*bh, ah*bl, ah*bh,
	// steps 1..4 accumulate the registered product in the next cycle. The
	// derivative then scales by 1e6 (issue at steps 5..8, accumulate 6..9).
	// Step 15 loads the derivative operands.
	always_comb begin
		case (step_q)
			4'd0: begin mul_a = ma_q[31:0];  mul_b = mb_q[31:0];  end
			4'd1: begin mul_a = ma_q[31:0];  mul_b = mb_q[63:32]; end
			4'd2: begin mul_a = ma_q[63:32]; mul_b = mb_q[31:0];  end
			4'd3: begin mul_a = ma_q[63:32]; mul_b = mb_q[63:32]; end
			4'd5: begin mul_a = acc_q[31:0];  mul_b = 32'(US_PER_S); end
			4'd6: begin mul_a = acc_q[63:32]; mul_b = 32'(US_PER_S); end
			4'd7: begin mul_a = acc_q[95:64]; mul_b = 32'(US_PER_S); end
			4'd8: begin mul_a = acc_q[127:96]; mul_b = 32'(US_PER_S); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// wrapped, saturated error
	logic signed [W-1:0] raw_err, unit_v, werr, serr;
	logic        [W-1:0] abs_err;
	always_comb begin
		raw_err = W'(item_q.setpoint) - W'(item_q.measured);
		unit_v  = item_q.half_period[31] ? -W'(item_q.half_period) : W'(item_q.half_period);
		werr    = raw_err;
		if (item_q.wrap_enable) begin
			if (raw_err > unit_v) werr = raw_err - (unit_v <<< 1);
			else if (raw_err < -unit_v) werr = raw_err + (unit_v <<< 1);
		end
		serr    = sat_f(werr);
		abs_err = serr[W-1] ? W'(-serr) : W'(serr);
	end

	logic signed [W-1:0] kx_diff;
	logic        [63:0] kx_mag;
	always_comb begin
		kx_diff = $signed(abs_err) - W'(knee_x_q);
		kx_mag  = kx_diff[W-1] ? 64'(-kx_diff) : 64'(kx_diff);
	end

	// signed magnitude -> saturated signed value
	function automatic logic signed [W-1:0] sgn_sat(input logic [127:0] m, input logic n);
		if (n) begin
			if (m > 128'(VMAX) + 128'd1) return VMIN;
			return -$signed(W'(m));
		end
		if (m > 128'(VMAX)) return VMAX;
		return $signed(W'(m));
	endfunction

	logic [127:0] pp_add;
	always_comb begin
		case (step_q)
			4'd1, 4'd6:  pp_add = 128'(mul_p);
			4'd2, 4'd3, 4'd7:  pp_add = 128'(mul_p) << 32;
			4'd4, 4'd8:  pp_add = 128'(mul_p) << 64;
			4'd9:  pp_add = 128'(mul_p) << 96;
			default: pp_add = '0;
		endcase
	end

	logic [127:0] scaled_q;
	logic signed [W-1:0] yk, t_root, sum_v, lim_v, clamp_v;
	logic         [63:0] dt_den;
	assign dt_den = 64'(dt_q) << FRAC_BITS;

	always_comb begin
		yk     = sat_f($signed(W'(it_res[63:0])) + W'(knee_y_q));
		t_root = (err_q > 0) ? yk : sat_f(-yk);
		sum_v  = sat_f(drive_q + dterm_q);
		lim_v  = W'(limit_q);
		clamp_v = sum_v;
		if (clamp_v > lim_v) clamp_v = lim_v;
		if (clamp_v < -lim_v) clamp_v = -lim_v;
	end

	// start pulses for one cycle; the sequencer moves on to a wait step
	always_comb begin
		it_ctl.start = 1'b0;
		it_ctl.op    = OP_SQRT;
		it_num       = '0;
		it_den       = '0;
		if (state_q == ST_SQRT && step_q == 4'd5) begin
			it_ctl.start = 1'b1;
			it_num = {64'd0, (acc_q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_q[63:0]};
		end else if (state_q == ST_DMUL && step_q == 4'd10) begin
			it_ctl.start = 1'b1;
			it_ctl.op    = OP_DIV;
			it_num       = scaled_q;
			it_den       = dt_den;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			out_valid <= 1'b0;
			step_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) begin
					item_q  <= in_data;
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= serr;
					step_q  <= '0;
					acc_q   <= '0;
					dterm_q <= '0;
					dt_q    <= (item_q.elapsed_us < 24'(DT_FLOOR_US)) ?
						24'(DT_FLOOR_US) : item_q.elapsed_us;
					if (dead_q != 0 && abs_err < W'(dead_q)) begin
						out_data.drive        <= '0;
						out_data.in_dead_band <= 1'b1;
						out_valid <= 1'b1;
						state_q   <= ST_WAIT;
					end else if (abs_err <= W'(linear_q)) begin
						ma_q  <= abs_err[63:0];
						mb_q  <= gain_p_q[31] ? 64'(-W'(gain_p_q)) : 64'(gain_p_q);
						neg_q <= serr[W-1] ^ gain_p_q[31];
						state_q <= ST_PMUL;
					end else begin
						ma_q  <= 64'(accel_q);
						mb_q  <= kx_mag;
						state_q <= ST_SQRT;
					end
				end
				ST_PMUL: begin
					acc_q <= acc_q + pp_add;
					if (step_q == 4'd4) begin
						drive_q <= sgn_sat((acc_q + pp_add) >> FRAC_BITS, neg_q);
						step_q  <= 4'd15;
						state_q <= ST_DMUL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					if (step_q < 4'd5) begin
						step_q <= step_q + 1'b1;
						acc_q  <= acc_q + pp_add;
					end else if (step_q == 4'd5) begin
						step_q <= 4'd6;
					end else if (it_sts.done) begin
						drive_q <= t_root;
						step_q  <= 4'd15;
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL: begin
					// magnitudes of diff and kd, then product, then *1e6, then the division
					if (step_q == 4'd15) begin
						if (gain_d_q == 0) begin
							state_q <= ST_SUM;
						end else begin
							acc_q <= '0;
							ma_q  <= ((err_q - prev_q) < 0) ? 64'(-(err_q - prev_q)) :
								64'(err_q - prev_q);
							mb_q  <= gain_d_q[31] ? 64'(-W'(gain_d_q)) : 64'(gain_d_q);
							neg_q <= ((err_q - prev_q) < 0) ^ gain_d_q[31];
							step_q <= '0;
						end
					end else if (step_q < 4'd5) begin
						step_q <= step_q + 1'b1;
						acc_q  <= acc_q + pp_add;
						if (step_q == 4'd4) scaled_q <= '0;
					end else if (step_q < 4'd10) begin
						step_q   <= step_q + 1'b1;
						scaled_q <= scaled_q + pp_add;
					end else if (step_q == 4'd10) begin
						step_q <= 4'd11;
					end else if (it_sts.done) begin
						dterm_q <= sgn_sat(it_res, neg_q);
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					out_data.drive        <= clamp_v[31:0];
					out_data.in_dead_band <= 1'b0;
					prev_q    <= err_q;
					out_valid <= 1'b1;
					state_q   <= ST_WAIT;
				end
				ST_WAIT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	`NSPD_ASSERT_IMP(a_out_only_wait, out_valid, state_q == ST_WAIT)
	`NSPD_ASSERT_NXT(a_accept_busy, in_valid && in_ready, !in_ready)
	`NSPD_ASSERT_IMP(a_dead_zero, out_valid && out_data.in_dead_band, out_data.drive == 0)
endmodule

@@ hdl/nspd_iter_unit.sv @@
// Shared shift-subtract unit: integer square root (two bits per step) or
// restoring division (one quotient bit per step).
module nspd_iter_unit import nspd_pkg::*; #(
	parameter int unsigned NUM_WIDTH = 128,
	parameter int unsigned DEN_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iter_ctl_t            ctl,
	input  logic [NUM_WIDTH-1:0] num,
	input  logic [DEN_WIDTH-1:0] den,
	output iter_sts_t            sts,
	output logic [NUM_WIDTH-1:0] result
);
	localparam int unsigned CW = $clog2(NUM_WIDTH + 1);
	localparam int unsigned RW = DEN_WIDTH + 2;

	logic [NUM_WIDTH-1:0] shift_q;
	logic [NUM_WIDTH-1:0] quot_q;
	logic [RW-1:0]        rem_q;
	logic [DEN_WIDTH-1:0] den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	iter_op_t             op_q;

	logic [RW-1:0] trial_rem;
	logic [RW-1:0] trial_sub;
	logic          take;

	always_comb begin
		if (op_q == OP_SQRT) begin
			trial_rem = {rem_q[RW-3:0], shift_q[NUM_WIDTH-1 -: 2]};
			trial_sub = {quot_q[RW-3:0], 2'b01};
		end else begin
			trial_rem = {rem_q[RW-2:0], shift_q[NUM_WIDTH-1]};
			trial_sub = {2'b00, den_q};
		end
		take = trial_rem >= trial_sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_SQRT;
		end else begin
			// one-cycle pulse after the last step
			done_q <= busy_q && !ctl.start && (cnt_q == CW'(1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == OP_SQRT) ? CW'(NUM_WIDTH / 2) : CW'(NUM_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			shift_q <= num;
			den_q   <= den;
			rem_q   <= '0;
			quot_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= take ? trial_rem - trial_sub : trial_rem;
			quot_q <= {quot_q[NUM_WIDTH-2:0], take};
			if (op_q == OP_SQRT) begin
				shift_q <= {shift_q[NUM_WIDTH-3:0], 2'b00};
			end else begin
				shift_q <= {shift_q[NUM_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign result   = quot_q;
endmodule

@@ hdl/nspd_mul_unit.sv @@
// Shared 32x32 multiplier; wide products are built from partial products
// accumulated by the sequencer.
module nspd_mul_unit #(
	parameter int unsigned W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

@@ sim/nonlinear_sqrt_pd_controller_test.sv @@
`timescale 1ns / 100ps

module nonlinear_sqrt_pd_controller_test;
	import nspd_pkg::*;

	localparam int FRAC = 16;
	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;

	// Control-law predictor plus the queue of drive beats still owed by the block.
	class ctrl_scoreboard;
		longint kp, kd, kx, ky;
		longint accel, lin, lim, dead;
		longint prev_err;
		out_item_t pending[$];
		int errors;

		function new();
			kp = 0; kd = 0; kx = 0; ky = 0;
			accel = 0; lin = 0; lim = 0; dead = 0;
			prev_err = 0; errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_GAIN_P: kp = longint'($signed(v));
				REG_GAIN_D: kd = longint'($signed(v));
				REG_ACCEL:  accel = longint'(v[30:0]);
				REG_LINEAR: lin = longint'(v[30:0]);
				REG_LIMIT:  lim = longint'(v[30:0]);
				REG_DEAD:   dead = longint'(v[30:0]);
				REG_KNEE_X: kx = longint'($signed(v));
				REG_KNEE_Y: ky = longint'($signed(v));
				default: ;
			endcase
		endfunction

		static function longint sat(longint v);
			if (v > VMAX) return VMAX;
			if (v < VMIN) return VMIN;
			return v;
		endfunction

		static function logic [127:0] mag(longint v);
			return {64'd0, (v < 0) ? 64'(-v) : 64'(v)};
		endfunction

		// magnitude and sign back to a saturated signed value
		static function longint sign_sat(logic [127:0] m, bit neg);
			if (neg) begin
				if (m > 128'd2147483648) return VMIN;
				return -longint'(m[63:0]);
			end
			if (m > 128'd2147483647) return VMAX;
			return longint'(m[63:0]);
		endfunction

		static function longint qmul(longint a, longint b);
			logic [127:0] p;
			p = (mag(a) * mag(b)) >> FRAC;
			return sign_sat(p, (a < 0) != (b < 0));
		endfunction

		static function logic [63:0] root64(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function void note(in_item_t it);
			longint err, span, t, drive, dt;
			logic [127:0] rad, num, den;
			out_item_t exp_beat;
			err = longint'($signed(it.setpoint)) - longint'($signed(it.measured));
			span = longint'($signed(it.half_period));
			if (span < 0) span = -span;
			if (it.wrap_enable) begin
				if (err > span) err = err - 2 * span;
				else if (err < -span) err = err + 2 * span;
			end
			err = sat(err);
			if (dead != 0 && mag(err) < dead) begin
				exp_beat.drive = '0;
				exp_beat.in_dead_band = 1'b1;
				pending.push_back(exp_beat);
				return;
			end
			if (mag(err) <= lin) begin
				drive = qmul(err, kp);
			end else begin
				// square-root branch; product fits 63 bits so no 2^64 cap is reached
				rad = mag(accel) * mag(longint'(mag(err)) - kx);
				t = sat(longint'(root64(rad[63:0])) + ky);
				drive = (err > 0) ? t : sat(-t);
			end
			if (kd != 0) begin
				dt = longint'(it.elapsed_us);
				if (dt < DT_FLOOR_US) dt = DT_FLOOR_US;
				num = mag(err - prev_err) * mag(kd) * 128'(US_PER_S);
				den = 128'(dt) << FRAC;
				drive = sat(drive + sign_sat(num / den, ((err - prev_err) < 0) != (kd < 0)));
			end
			if (drive > lim) drive = lim;
			if (drive < -lim) drive = -lim;
			prev_err = err;
			exp_beat.drive = 32'(drive);
			exp_beat.in_dead_band = 1'b0;
			pending.push_back(exp_beat);
		endfunction

		function void check(out_item_t act);
			out_item_t exp_beat;
			if (pending.size() == 0) begin
				$display("%0t: unexpected drive beat %h/%b", $time, act.drive, act.in_dead_band);
				errors++;
				return;
			end
			exp_beat = pending.pop_front();
			if (act.drive !== exp_beat.drive) begin
				$display("%0t: drive expected %h actual %h", $time, exp_beat.drive, act.drive);
				errors++;
			end
			if (act.in_dead_band !== exp_beat.in_dead_band) begin
				$display("%0t: in_dead_band expected %b actual %b", $time,
					exp_beat.in_dead_band, act.in_dead_band);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	ctrl_scoreboard sb = new();

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	nonlinear_sqrt_pd_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Beat monitor: samples pre-edge values, so no race with the block's flops.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note(in_data);
		if (arst_n && out_valid && out_ready) sb.check(out_data);
	end

	// Receiver stall pattern: whenever the low byte of rx_cnt is zero the mode is
	// redrawn at random from always ready, coin flip, and mostly stalled.
	int unsigned rx_cnt = 0;
	int unsigned rx_mode = 0;
	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if (rx_cnt[7:0] == 8'd0) rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Write enable stays high across consecutive writes; write_all drops it.
	task automatic write_reg(logic [2:0] idx, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic write_all(logic [31:0] p, logic [31:0] d, logic [31:0] a,
		logic [31:0] l, logic [31:0] m, logic [31:0] z, logic [31:0] x, logic [31:0] y);
		write_reg(REG_GAIN_P, p);
		write_reg(REG_GAIN_D, d);
		write_reg(REG_ACCEL, a);
		write_reg(REG_LINEAR, l);
		write_reg(REG_LIMIT, m);
		write_reg(REG_DEAD, z);
		write_reg(REG_KNEE_X, x);
		write_reg(REG_KNEE_Y, y);
		cfg_we <= 1'b0;
	endtask

	// Holds valid until the beat is taken; valid stays high for a back-to-back beat.
	task automatic send_beat(in_item_t it);
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random gap after a beat outside a burst; burst position kept in burst_left.
	int unsigned burst_left = 0;
	task automatic pace();
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 20);
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [31:0] scaled();
		logic [31:0] r;
		r = $urandom;
		return $signed(r) >>> $urandom_range(0, 31);
	endfunction

	function automatic in_item_t mk(logic [31:0] sp, logic [31:0] ms, logic w,
		logic [31:0] hp, logic [23:0] us);
		in_item_t it;
		it.setpoint = sp;
		it.measured = ms;
		it.wrap_enable = w;
		it.half_period = hp;
		it.elapsed_us = us;
		return it;
	endfunction

	function automatic in_item_t rand_item();
		logic [31:0] sp, hp;
		logic [23:0] us;
		sp = $urandom;
		case ($urandom_range(0, 5))
			0: hp = $urandom;
			1: hp = 32'h8000_0000;
			default: hp = scaled();
		endcase
		us = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 250)) : 24'($urandom);
		// mostly a small error around the setpoint, sometimes a wild measurement
		return mk(sp, ($urandom_range(0, 4) == 0) ? $urandom : sp - scaled(),
			$urandom_range(0, 2) == 0, hp, us);
	endfunction

	task automatic random_run(int n);
		repeat (n) begin
			send_beat(rand_item());
			pace();
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset configuration: everything zero, drive stays zero
		random_run(40);

		// realistic tuning: kp 2.0, kd 0.1, linear band 1.0, small dead band
		write_all(32'h0002_0000, 32'h0000_1999, 32'h0014_0000, 32'h0001_0000,
			32'h0064_0000, 32'h0000_0100, 32'h0000_6000, 32'h0000_C000);
		// directed: field extremes, dead band edge, wrap edges, dt floor
		send_beat(mk(32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0, 24'd0));
		send_beat(mk(32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, 24'hff_ffff));
		send_beat(mk(32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'h8000_0000, 24'd99));
		send_beat(mk(32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'h7fff_ffff, 24'd100));
		send_beat(mk(32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 24'd100));
		send_beat(mk(32'h0000_00ff, 32'h0000_0000, 1'b0, 32'h0, 24'd100));
		send_beat(mk(32'h0000_0100, 32'h0000_0000, 1'b0, 32'h0, 24'd101));
		send_beat(mk(32'h0000_0000, 32'h0000_0100, 1'b0, 32'h0, 24'd1));
		send_beat(mk(32'h0001_0000, 32'h0000_0000, 1'b0, 32'h0, 24'd1000));
		send_beat(mk(32'h0001_0001, 32'h0000_0000, 1'b0, 32'h0, 24'd1000));
		send_beat(mk(32'h0000_0000, 32'h0001_0001, 1'b0, 32'h0, 24'd1000));
		send_beat(mk(32'h0005_0000, 32'h0000_0000, 1'b1, 32'h0004_0000, 24'd500));
		send_beat(mk(32'h0000_0000, 32'h0005_0000, 1'b1, 32'hfffc_0000, 24'd500));
		send_beat(mk(32'h0004_0000, 32'h0000_0000, 1'b1, 32'h0004_0000, 24'd500));
		send_beat(mk(32'h0003_0000, 32'h0000_0000, 1'b1, 32'h0004_0000, 24'd500));
		send_beat(mk(32'h0123_4567, 32'hfedc_ba98, 1'b0, 32'h0, 24'd0));
		drain();
		random_run(100);

		// positive extremes, linear band at its top value
		write_all(32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		random_run(80);

		// negative extremes, square-root branch for every nonzero error, limit at its top value
		write_all(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
			32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(mk(32'h7fff_ffff, 32'h8000_0000, 1'b0, 32'h0, 24'd0));
		send_beat(mk(32'h8000_0000, 32'h7fff_ffff, 1'b0, 32'h0, 24'd0));
		drain();
		random_run(80);

		// zero output limit, huge dead band
		write_all(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_1000,
			32'h0000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
		random_run(60);

		repeat (6) begin
			write_all($urandom, ($urandom_range(0, 3) == 0) ? 32'h0 : scaled(), $urandom,
				scaled(), ($urandom_range(0, 1) == 0) ? $urandom : scaled(),
				($urandom_range(0, 1) == 0) ? 32'h0 : scaled() >>> 4, scaled(), scaled());
			random_run(80);
		end

		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#50000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
